### design/zbi_pkg.sv
// Shared types, codes and bit-interleave helpers for the Z-order box-to-intervals block.
// Used by zbi_box_unit, the top-level core, zbi_checker and testbench. No dependencies.
`timescale 1ns / 1ps
package zbi_pkg;

	localparam int MAX_DIMS = 4;
	localparam int COORD_W  = 15;
	localparam int CODE_W   = 31;
	localparam int CODE_IW  = 5;
	localparam int DIMS_W   = 3;
	localparam int BPD_W    = 4;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [MAX_DIMS-1:0][COORD_W-1:0] coord_arr_t;

	// Commands carried on the input selector.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_NEXT  = 1'b1;

	// Result status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_QUERY = 2'd1;
	localparam logic [1:0] STAT_BAD      = 2'd2;

	// Register indexes on the configuration port.
	localparam logic REG_DIMS = 1'b0;
	localparam logic REG_BPD  = 1'b1;

	// Result of one box test by the shared unit.
	typedef struct packed {
		logic       contain;
		logic       overlap;
		coord_arr_t mins;
	} box_res_t;

	// Code bit j*dims+d takes bit j of coordinate d.
	function automatic code_t interleave(coord_arr_t c, logic [DIMS_W-1:0] dims,
			logic [BPD_W-1:0] bpd);
		code_t z;
		int    pos;
		z = '0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			for (int j = 0; j < COORD_W; j++) begin
				pos = j * int'(dims) + d;
				if (d < int'(dims) && j < int'(bpd) && pos < CODE_W)
					z[CODE_IW'(pos)] = c[d][j];
			end
		end
		return z;
	endfunction

	// Inverse of interleave: pulls each coordinate out of a code.
	function automatic coord_arr_t deinterleave(code_t z, logic [DIMS_W-1:0] dims,
			logic [BPD_W-1:0] bpd);
		coord_arr_t c;
		int         pos;
		c = '0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			for (int j = 0; j < COORD_W; j++) begin
				pos = j * int'(dims) + d;
				if (d < int'(dims) && j < int'(bpd) && pos < CODE_W)
					c[d][j] = z[CODE_IW'(pos)];
			end
		end
		return c;
	endfunction

endpackage

### design/zbi_box_unit.sv
// Shared box test unit: checks an aligned block of Z-order codes against the box.
// Depends on zbi_pkg.
`timescale 1ns / 1ps
module zbi_box_unit (
	input  zbi_pkg::code_t                  base,
	input  zbi_pkg::code_t                  mask,
	input  logic [zbi_pkg::DIMS_W-1:0]      dims,
	input  logic [zbi_pkg::BPD_W-1:0]       bpd,
	input  zbi_pkg::coord_arr_t             box_lo,
	input  zbi_pkg::coord_arr_t             box_hi,
	output zbi_pkg::box_res_t               res
);
	import zbi_pkg::*;

	coord_arr_t blk_lo;
	coord_arr_t blk_span;
	coord_arr_t blk_hi;

	// The block runs from base to base|mask; per dimension that is an aligned range.
	assign blk_lo   = deinterleave(base, dims, bpd);
	assign blk_span = deinterleave(mask, dims, bpd);
	assign blk_hi   = blk_lo | blk_span;

	// Per-dimension containment, overlap and clipped lower corner.
	always_comb begin
		res.contain = 1'b1;
		res.overlap = 1'b1;
		res.mins    = '0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			res.mins[d] = (blk_lo[d] > box_lo[d]) ? blk_lo[d] : box_lo[d];
			if (d < int'(dims)) begin
				if (blk_lo[d] < box_lo[d] || blk_hi[d] > box_hi[d])
					res.contain = 1'b0;
				if (blk_lo[d] > box_hi[d] || blk_hi[d] < box_lo[d])
					res.overlap = 1'b0;
			end
		end
	end

endmodule

### design/zorder_box_to_intervals_core.sv
// Top level of the Z-order box-to-intervals block: stream ports, sequencer, result register.
// Depends on zbi_pkg and zbi_box_unit.
`timescale 1ns / 1ps
// A start request latches a box and returns the first run of consecutive Z-order codes
// inside it; each next request returns the following run, with tlast on the run that ends
// at the box's upper corner code. One request is worked on at a time through a single box
// test unit that checks one code block per cycle: a start request first checks the
// configuration and box and encodes the corners, then runs the search. The search extends
// the run by aligned blocks, trying block sizes from the largest aligned one down, and
// scans code bits to find the next run start. The next request is accepted while a
// finished result still waits in the output register.
// Configuration writes are taken only while the block is idle and no request is offered.
module zorder_box_to_intervals_core (
	input  logic         clk,
	input  logic         arst_n,
	// Input requests.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [119:0] s_tdata,  // low_0, low_1, low_2, low_3, high_0, high_1, high_2, high_3
	input  logic         s_tuser,  // cmd
	// Results.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // interval_left, interval_right, zero fill
	output logic         m_tlast,  // last
	output logic [1:0]   m_tuser,  // status
	// Configuration writes.
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [3:0]   cfg_data
);
	import zbi_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_START    = 8'b0000_0010,
		ST_RUN_NEXT = 8'b0000_0100,
		ST_RUN_K    = 8'b0000_1000,
		ST_MIN_X    = 8'b0001_0000,
		ST_MIN_P    = 8'b0010_0000,
		ST_MIN_FIN  = 8'b0100_0000,
		ST_DONE     = 8'b1000_0000
	} state_t;

	state_t                  state_q;
	logic [DIMS_W-1:0]       dims_q;
	logic [BPD_W-1:0]        bpd_q;
	logic                    active_q;
	coord_arr_t              box_lo_q;
	coord_arr_t              box_hi_q;
	code_t                   high_code_q;
	code_t                   cursor_q;
	code_t                   end_q;
	logic [CODE_IW-1:0]      k_q;
	logic [CODE_IW-1:0]      p_q;
	coord_arr_t              mins_q;
	code_t                   res_left_q;
	code_t                   res_right_q;
	logic                    res_last_q;
	logic [1:0]              res_status_q;

	logic                    in_fire;
	logic                    cfg_fire;
	logic                    out_free;
	coord_t                  coord_mask;
	coord_arr_t              in_lo;
	coord_arr_t              in_hi;
	logic [6:0]              nbits;
	logic                    cfg_ok;
	logic                    box_empty;
	code_t                   next_code;
	code_t                   k_mask;
	code_t                   p_mask;
	code_t                   p_bit;
	code_t                   cand;
	logic [CODE_IW-1:0]      next_tz;
	code_t                   unit_base;
	code_t                   unit_mask;
	box_res_t                unit_res;

	assign in_fire   = s_tvalid && s_tready;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !s_tvalid;
	assign out_free  = !m_tvalid || m_tready;

	// Incoming corners, with coordinate bits above bits_per_dim dropped.
	assign coord_mask = COORD_W'((16'd1 << bpd_q) - 16'd1);
	always_comb begin
		for (int d = 0; d < MAX_DIMS; d++) begin
			in_lo[d] = s_tdata[d*COORD_W +: COORD_W] & coord_mask;
			in_hi[d] = s_tdata[(MAX_DIMS+d)*COORD_W +: COORD_W] & coord_mask;
		end
	end

	// Configuration and box sanity checks.
	assign nbits  = 7'(dims_q * bpd_q);
	assign cfg_ok = (dims_q >= 3'd1) && (dims_q <= 3'(MAX_DIMS)) && (bpd_q >= 4'd1) &&
			(nbits <= 7'(CODE_W));
	always_comb begin
		box_empty = 1'b0;
		for (int d = 0; d < MAX_DIMS; d++)
			if (d < int'(dims_q) && box_lo_q[d] > box_hi_q[d])
				box_empty = 1'b1;
	end

	// Code arithmetic around the current run end.
	assign next_code = end_q + code_t'(1);
	assign k_mask    = CODE_W'((32'd1 << k_q) - 32'd1);
	assign p_mask    = CODE_W'((32'd1 << p_q) - 32'd1);
	assign p_bit     = CODE_W'(32'd1 << p_q);
	assign cand      = (next_code & ~p_mask) | p_bit;

	// Trailing zero count of the code after the run end.
	always_comb begin
		next_tz = '0;
		for (int i = CODE_W - 1; i >= 0; i--)
			if (next_code[i])
				next_tz = CODE_IW'(i);
	end

	// The shared unit tests one block per cycle; the state picks which.
	always_comb begin
		unit_base = next_code;
		unit_mask = '0;
		case (state_q)
			ST_RUN_K: unit_mask = k_mask;
			ST_MIN_P: begin
				unit_base = cand;
				unit_mask = p_mask;
			end
			default: unit_mask = '0;
		endcase
	end

	zbi_box_unit u_box (
		.base   (unit_base),
		.mask   (unit_mask),
		.dims   (dims_q),
		.bpd    (bpd_q),
		.box_lo (box_lo_q),
		.box_hi (box_hi_q),
		.res    (unit_res)
	);

	// Box corners are only read while a request is being worked on.
	always_ff @(posedge clk) begin
		if (in_fire && s_tuser == CMD_START) begin
			box_lo_q <= in_lo;
			box_hi_q <= in_hi;
		end
		if (state_q == ST_MIN_P)
			mins_q <= unit_res.mins;
	end

	// Sequencer and query state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dims_q       <= 3'd2;
			bpd_q        <= 4'd8;
			active_q     <= 1'b0;
			high_code_q  <= '0;
			cursor_q     <= '0;
			end_q        <= '0;
			k_q          <= '0;
			p_q          <= '0;
			res_left_q   <= '0;
			res_right_q  <= '0;
			res_last_q   <= 1'b0;
			res_status_q <= STAT_OK;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tlast      <= 1'b0;
			m_tuser      <= STAT_OK;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_DONE)
				m_tvalid <= 1'b0;

			if (cfg_fire) begin
				active_q <= 1'b0;
				case (cfg_index)
					REG_DIMS: dims_q <= cfg_data[DIMS_W-1:0];
					REG_BPD:  bpd_q  <= cfg_data;
					default:  dims_q <= dims_q;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (s_tuser == CMD_NEXT) begin
							if (!active_q) begin
								res_left_q   <= '0;
								res_right_q  <= '0;
								res_last_q   <= 1'b0;
								res_status_q <= STAT_NO_QUERY;
								state_q      <= ST_DONE;
							end else begin
								res_left_q <= cursor_q;
								end_q      <= cursor_q;
								state_q    <= ST_RUN_NEXT;
							end
						end else begin
							active_q <= 1'b0;
							state_q  <= ST_START;
						end
					end
				end
				ST_START: begin
					if (!cfg_ok || box_empty) begin
						res_left_q   <= '0;
						res_right_q  <= '0;
						res_last_q   <= 1'b0;
						res_status_q <= STAT_BAD;
						state_q      <= ST_DONE;
					end else begin
						high_code_q <= interleave(box_hi_q, dims_q, bpd_q);
						end_q       <= interleave(box_lo_q, dims_q, bpd_q);
						res_left_q  <= interleave(box_lo_q, dims_q, bpd_q);
						state_q     <= ST_RUN_NEXT;
					end
				end
				// Extend the run one aligned block at a time.
				ST_RUN_NEXT: begin
					if (end_q >= high_code_q) begin
						res_right_q  <= high_code_q;
						res_last_q   <= 1'b1;
						res_status_q <= STAT_OK;
						active_q     <= 1'b0;
						state_q      <= ST_DONE;
					end else if (!unit_res.contain) begin
						res_right_q <= end_q;
						state_q     <= ST_MIN_X;
					end else begin
						k_q     <= next_tz;
						state_q <= ST_RUN_K;
					end
				end
				ST_RUN_K: begin
					if (k_q == '0 || unit_res.contain) begin
						end_q   <= next_code | k_mask;
						state_q <= ST_RUN_NEXT;
					end else begin
						k_q <= k_q - CODE_IW'(1);
					end
				end
				// Find the smallest in-box code after the run.
				ST_MIN_X: begin
					if (unit_res.contain) begin
						cursor_q     <= next_code;
						res_last_q   <= 1'b0;
						res_status_q <= STAT_OK;
						active_q     <= 1'b1;
						state_q      <= ST_DONE;
					end else begin
						p_q     <= '0;
						state_q <= ST_MIN_P;
					end
				end
				ST_MIN_P: begin
					if (!next_code[p_q] && unit_res.overlap) begin
						state_q <= ST_MIN_FIN;
					end else if (7'(p_q) + 7'd1 >= nbits) begin
						cursor_q     <= high_code_q;
						res_last_q   <= 1'b0;
						res_status_q <= STAT_OK;
						active_q     <= 1'b1;
						state_q      <= ST_DONE;
					end else begin
						p_q <= p_q + CODE_IW'(1);
					end
				end
				ST_MIN_FIN: begin
					cursor_q     <= interleave(mins_q, dims_q, bpd_q);
					res_last_q   <= 1'b0;
					res_status_q <= STAT_OK;
					active_q     <= 1'b1;
					state_q      <= ST_DONE;
				end
				// Hand the result to the output register once it is free.
				ST_DONE: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {2'b00, res_right_q, res_left_q};
						m_tlast  <= res_last_q;
						m_tuser  <= res_status_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### design/zbi_checker.sv
// Port-level checks for zorder_box_to_intervals_core, attached by bind.
// Depends on zbi_pkg.
`timescale 1ns / 1ps
module zbi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tlast,
	input logic [1:0]  m_tuser
);
	import zbi_pkg::*;

	// A stalled result keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
			$stable(m_tuser))
		else $error("stalled result changed");

	// Error results carry no run.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STAT_OK |-> m_tdata == '0 && !m_tlast)
		else $error("error result carries data");

	// A run never ends before it starts.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_OK |-> m_tdata[61:31] >= m_tdata[30:0])
		else $error("run end below run start");

	// Only defined status codes appear, and the fill bits stay clear.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 2'd3 && m_tdata[63:62] == 2'b00)
		else $error("undefined status or fill bits");

endmodule

bind zorder_box_to_intervals_core zbi_checker u_zbi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

### dv/testbench.sv
// Self-checking testbench for zorder_box_to_intervals_core: box starts and next-run requests
// are checked against an in-bench Z-order run predictor. Depends on zbi_pkg and the core RTL.
`timescale 1ns / 1ps
module testbench;
	import zbi_pkg::*;

	typedef struct packed {
		logic [30:0] left;
		logic [30:0] right;
		logic        last;
		logic [1:0]  status;
	} run_t;

	typedef struct {
		logic        cmd;
		logic [14:0] lo [4];
		logic [14:0] hi [4];
		bit          typed;
		run_t        run;
	} req_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [119:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic         m_tlast;
	logic [1:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_index;
	logic [3:0]   cfg_data;

	// Predictor state: configuration, latched box and run cursor.
	int unsigned     zp_dims;
	int unsigned     zp_bpd;
	int unsigned     zp_lo [4];
	int unsigned     zp_hi [4];
	longint unsigned zp_low_code;
	longint unsigned zp_high_code;
	longint unsigned zp_cursor;
	bit              zp_active;

	run_t run_q [$];
	req_t directed [$];
	int   errors;

	zorder_box_to_intervals_core dut (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		#100ms;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report(string what);
		errors++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	// Bit j of coordinate d sits at code bit j*dims+d.
	function automatic int unsigned coord_of(longint unsigned z, int unsigned d);
		int unsigned v;
		v = 0;
		for (int unsigned j = 0; j < zp_bpd; j++)
			v |= int'((z >> (j * zp_dims + d)) & 1) << j;
		return v;
	endfunction

	function automatic longint unsigned weave(int unsigned c [4]);
		longint unsigned z;
		z = 0;
		for (int unsigned d = 0; d < zp_dims && d < 4; d++)
			for (int unsigned j = 0; j < zp_bpd; j++)
				z |= longint'((c[d] >> j) & 1) << (j * zp_dims + d);
		return z;
	endfunction

	function automatic bit inside_box(longint unsigned z);
		int unsigned c;
		for (int unsigned d = 0; d < zp_dims && d < 4; d++) begin
			c = coord_of(z, d);
			if (c < zp_lo[d] || c > zp_hi[d])
				return 0;
		end
		return 1;
	endfunction

	// Last code of the in-box run holding cur, widening by aligned blocks.
	function automatic longint unsigned run_stop(longint unsigned cur);
		longint unsigned e;
		longint unsigned nx;
		int unsigned     k;
		e = cur;
		while (e < zp_high_code) begin
			nx = e + 1;
			k = 0;
			if (!inside_box(nx))
				break;
			while (k < zp_dims * zp_bpd && ((nx >> k) & 1) == 0)
				k++;
			while (k > 0 && !inside_box(nx | ((longint'(1) << k) - 1)))
				k--;
			e = nx | ((longint'(1) << k) - 1);
		end
		return e;
	endfunction

	// Smallest in-box code at or above x.
	function automatic longint unsigned jump_in(longint unsigned x);
		longint unsigned cand;
		int unsigned     mins [4];
		int unsigned     r, lo, hi;
		bit              ok;
		if (inside_box(x))
			return x;
		for (int unsigned p = 0; p < zp_dims * zp_bpd; p++) begin
			if ((x >> p) & 1)
				continue;
			cand = ((x >> p) | 1) << p;
			ok = 1;
			mins = '{0, 0, 0, 0};
			for (int unsigned d = 0; d < zp_dims && d < 4; d++) begin
				r = 0;
				while (r < zp_bpd && r * zp_dims + d < p)
					r++;
				lo = coord_of(cand, d);
				hi = lo | ((1 << r) - 1);
				if (lo > zp_hi[d] || hi < zp_lo[d]) begin
					ok = 0;
					break;
				end
				mins[d] = lo > zp_lo[d] ? lo : zp_lo[d];
			end
			if (ok)
				return weave(mins);
		end
		return zp_high_code;
	endfunction

	function automatic run_t next_run();
		run_t            res;
		longint unsigned right;
		res.left = zp_cursor[30:0];
		res.status = STAT_OK;
		right = run_stop(zp_cursor);
		if (right >= zp_high_code) begin
			zp_active = 0;
			res.right = zp_high_code[30:0];
			res.last = 1'b1;
		end else begin
			zp_cursor = jump_in(right + 1);
			zp_active = 1;
			res.right = right[30:0];
			res.last = 1'b0;
		end
		return res;
	endfunction

	// Expected result of one accepted request; updates the predictor state.
	function automatic run_t predict_run(req_t rq);
		run_t        err;
		int unsigned m;
		err = '0;
		if (rq.cmd == CMD_NEXT) begin
			err.status = STAT_NO_QUERY;
			return zp_active ? next_run() : err;
		end
		zp_active = 0;
		err.status = STAT_BAD;
		if (zp_dims < 1 || zp_dims > 4 || zp_bpd < 1 || zp_bpd > 15 || zp_dims * zp_bpd > 31)
			return err;
		m = (1 << zp_bpd) - 1;
		for (int d = 0; d < 4; d++) begin
			zp_lo[d] = rq.lo[d] & m;
			zp_hi[d] = rq.hi[d] & m;
		end
		for (int unsigned d = 0; d < zp_dims; d++)
			if (zp_lo[d] > zp_hi[d])
				return err;
		zp_low_code = weave(zp_lo);
		zp_high_code = weave(zp_hi);
		zp_cursor = zp_low_code;
		return next_run();
	endfunction

	// Short idle stretches mostly, a few long ones.
	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		else if (k < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Present one request, wait for its handshake, then record its expectation.
	task automatic send_req(req_t rq);
		int   g;
		bit   hs;
		run_t want;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= rq.cmd;
		s_tdata <= {rq.hi[3], rq.hi[2], rq.hi[1], rq.hi[0],
			rq.lo[3], rq.lo[2], rq.lo[1], rq.lo[0]};
		do begin
			@(negedge clk);
			hs = s_tready;
			@(posedge clk);
		end while (!hs);
		want = predict_run(rq);
		run_q = {run_q, (rq.typed ? rq.run : want)};
	endtask

	task automatic write_reg(logic idx, logic [3:0] val);
		bit hs;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			hs = cfg_ready;
			@(posedge clk);
		end while (!hs);
		zp_active = 0;
		if (idx == REG_DIMS)
			zp_dims = val & 7;
		else
			zp_bpd = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Let every outstanding result come back before touching the registers.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (run_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic req_t make_req(logic cmd, int l0, int h0, int l1, int h1,
			int l2 = 0, int h2 = 0, int l3 = 0, int h3 = 0);
		req_t rq;
		rq.cmd = cmd;
		rq.lo = '{15'(l0), 15'(l1), 15'(l2), 15'(l3)};
		rq.hi = '{15'(h0), 15'(h1), 15'(h2), 15'(h3)};
		rq.typed = 0;
		rq.run = '0;
		return rq;
	endfunction

	function automatic req_t typed_req(req_t rq, int left, int right, bit last, logic [1:0] st);
		rq.typed = 1;
		rq.run = '{left[30:0], right[30:0], last, st};
		return rq;
	endfunction

	// Random box: corners within the active bits, with junk in the ignored upper bits.
	function automatic req_t random_box();
		req_t        rq;
		int unsigned m, a, b, t;
		rq = make_req(CMD_START, 0, 0, 0, 0);
		m = (zp_bpd >= 1 && zp_bpd <= 15) ? (1 << zp_bpd) - 1 : 15'h7fff;
		for (int d = 0; d < 4; d++) begin
			a = $urandom & m;
			if ($urandom_range(0, 2) == 0)
				b = $urandom & m;
			else
				b = a + $urandom_range(0, 9);
			if (b > m)
				b = m;
			if (b < a && $urandom_range(0, 9) != 0) begin
				t = a;
				a = b;
				b = t;
			end
			if ($urandom_range(0, 1))
				a |= $urandom & ~m;
			if ($urandom_range(0, 1))
				b |= $urandom & ~m;
			rq.lo[d] = a[14:0];
			rq.hi[d] = b[14:0];
			if (d >= zp_dims) begin
				rq.lo[d] = 15'($urandom);
				rq.hi[d] = 15'($urandom);
			end
		end
		return rq;
	endfunction

	// Mostly whole queries walked run by run, some abandoned, some stray next requests.
	task automatic random_phase(int count);
		int   sent;
		int   walk;
		req_t nxt;
		sent = 0;
		nxt = make_req(CMD_NEXT, 0, 0, 0, 0);
		while (sent < count) begin
			if ($urandom_range(0, 9) == 0) begin
				nxt.lo[0] = 15'($urandom);
				nxt.hi[3] = 15'($urandom);
				send_req(nxt);
				sent++;
			end
			send_req(random_box());
			sent++;
			walk = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : 40;
			while (zp_active && walk > 0 && sent < count) begin
				send_req(nxt);
				sent++;
				walk--;
			end
		end
	endtask

	// Result side: random back-pressure and in-order comparison.
	initial begin
		bit   take;
		bit   steady;
		run_t got;
		run_t want;
		m_tready <= 1'b0;
		steady = 0;
		forever begin
			@(negedge clk);
			take = m_tvalid && m_tready;
			got = '{m_tdata[30:0], m_tdata[61:31], m_tlast, m_tuser};
			@(posedge clk);
			if (take) begin
				if (run_q.size() == 0) begin
					report("result with nothing expected");
				end else begin
					want = run_q.pop_front();
					if (got.left !== want.left)
						report($sformatf("left %0h want %0h", got.left, want.left));
					if (got.right !== want.right)
						report($sformatf("right %0h want %0h", got.right, want.right));
					if (got.last !== want.last)
						report($sformatf("last %0b want %0b", got.last, want.last));
					if (got.status !== want.status)
						report($sformatf("status %0d want %0d", got.status, want.status));
				end
			end
			if ($urandom_range(0, 199) == 0)
				steady = !steady;
			if (steady)
				m_tready <= 1'b1;
			else if ($urandom_range(0, 19) == 0)
				m_tready <= 1'b0;
			else
				m_tready <= gap_len() == 0;
		end
	end

	// Stimulus: directed table, then random phases over several configurations.
	initial begin
		req_t nx;
		int   cfgs [12][2];
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_START;
		cfg_valid <= 1'b0;
		cfg_index <= REG_DIMS;
		cfg_data <= '0;
		errors = 0;
		zp_dims = 2;
		zp_bpd = 8;
		zp_active = 0;
		zp_low_code = 0;
		zp_high_code = 0;
		zp_cursor = 0;
		zp_lo = '{0, 0, 0, 0};
		zp_hi = '{0, 0, 0, 0};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		nx = make_req(CMD_NEXT, 0, 0, 0, 0);
		directed = {directed, typed_req(nx, 0, 0, 0, STAT_NO_QUERY)};
		directed = {directed, typed_req(make_req(CMD_START, 0, 255, 0, 255), 0, 'hffff, 1,
			STAT_OK)};
		directed = {directed, typed_req(nx, 0, 0, 0, STAT_NO_QUERY)};
		directed = {directed, typed_req(make_req(CMD_START, 10, 3, 0, 255), 0, 0, 0,
			STAT_BAD)};
		directed = {directed, typed_req(nx, 0, 0, 0, STAT_NO_QUERY)};
		directed = {directed, typed_req(make_req(CMD_START, 'h7fff, 'h7fff, 'h7fff, 'h7fff,
			'h7fff, 'h7fff, 'h7fff, 'h7fff), 'hffff, 'hffff, 1, STAT_OK)};
		directed = {directed, typed_req(make_req(CMD_START, 0, 0, 0, 0), 0, 0, 1, STAT_OK)};
		directed = {directed, make_req(CMD_START, 3, 9, 2, 12, 'h7000, 'h0012, 'h55, 'h2)};
		for (int i = 0; i < 5; i++)
			directed = {directed, nx};
		directed = {directed, make_req(CMD_START, 'h7f03, 'h0005, 'h2a01, 'h5506)};
		for (int i = 0; i < 4; i++)
			directed = {directed, nx};
		directed = {directed, make_req(CMD_START, 100, 200, 17, 18)};
		directed = {directed, nx};
		directed = {directed, nx};
		foreach (directed[i])
			send_req(directed[i]);
		random_phase(150);
		drain();

		// Extremes of each register plus configurations the block must refuse.
		cfgs = '{'{1, 1}, '{1, 15}, '{4, 7}, '{3, 10}, '{2, 15}, '{4, 1}, '{0, 5},
			'{4, 8}, '{7, 15}, '{1, 0}, '{3, 1}, '{2, 8}};
		foreach (cfgs[i]) begin
			write_reg(REG_DIMS, 4'(cfgs[i][0]));
			write_reg(REG_BPD, 4'(cfgs[i][1]));
			@(posedge clk);
			if (zp_dims < 1 || zp_dims > 4 || zp_bpd < 1 || zp_dims * zp_bpd > 31)
				random_phase(12);
			else
				random_phase(105);
			drain();
		end

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
design/zbi_pkg.sv
design/zbi_box_unit.sv
design/zorder_box_to_intervals_core.sv
design/zbi_checker.sv
dv/testbench.sv
